### sv/sorted_ring_priority_queue_defines.svh
// Assertion macros shared by the sorted ring priority queue RTL.
`ifndef SORTED_RING_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_RING_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent on a clock edge implies consequent on the same edge.
`define SRPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srpq: implication check failed");
// Expression never holds on a clock edge.
`define SRPQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("srpq: forbidden condition seen");
`else
`define SRPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SRPQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### sv/srpq_pkg.sv
// Shared types and constants of the sorted ring priority queue.
`timescale 1ns / 1ps
package srpq_pkg;

  localparam int KEY_W        = 32;
  localparam int OCC_W        = 5;
  localparam int CAPACITY_DEF = 16;

  // Input operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_POP
  } state_e;

  // Kind of result to post at the end of a request.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_INS,
    RES_REJ,
    RES_REM,
    RES_EMPTY
  } res_kind_e;

  typedef struct packed {
    logic      accept;       // capture key and tail slot
    logic      rd_tail_prev; // read slot before the tail
    logic      rd_head;      // read head slot
    logic      rd_walk;      // read slot before the predecessor
    logic      wr_shift;     // move predecessor key up one slot
    logic      wr_key;       // write the new key at the hole
    res_kind_e result;       // finish the request with this result
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic key_less;      // new key strictly below its predecessor
    logic prev_is_head;  // predecessor slot is the head slot
  } status_t;

endpackage

### sv/srpq_ctrl.sv
// Request sequencer of the sorted ring priority queue.
`timescale 1ns / 1ps
module srpq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             op_i,
  input  srpq_pkg::status_t status_i,
  output srpq_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  srpq_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srpq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.result = srpq_pkg::RES_NONE;
    case (state_q)
      srpq_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op_i == srpq_pkg::OP_INSERT) begin
            if (status_i.full) begin
              cmd_o.result = srpq_pkg::RES_REJ;
            end else if (status_i.empty) begin
              cmd_o.accept = 1'b1;
              state_d      = srpq_pkg::ST_PLACE;
            end else begin
              cmd_o.accept       = 1'b1;
              cmd_o.rd_tail_prev = 1'b1;
              state_d            = srpq_pkg::ST_SHIFT;
            end
          end else begin
            if (status_i.empty) begin
              cmd_o.result = srpq_pkg::RES_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = srpq_pkg::ST_POP;
            end
          end
        end
      end
      srpq_pkg::ST_SHIFT: begin
        // Compare against the predecessor; shift it up or drop the key in.
        if (status_i.key_less) begin
          cmd_o.wr_shift = 1'b1;
          if (status_i.prev_is_head) begin
            state_d = srpq_pkg::ST_PLACE;
          end else begin
            cmd_o.rd_walk = 1'b1;
          end
        end else begin
          cmd_o.wr_key = 1'b1;
          cmd_o.result = srpq_pkg::RES_INS;
          state_d      = srpq_pkg::ST_IDLE;
        end
      end
      srpq_pkg::ST_PLACE: begin
        cmd_o.wr_key = 1'b1;
        cmd_o.result = srpq_pkg::RES_INS;
        state_d      = srpq_pkg::ST_IDLE;
      end
      srpq_pkg::ST_POP: begin
        cmd_o.result = srpq_pkg::RES_REM;
        state_d      = srpq_pkg::ST_IDLE;
      end
      default: begin
        state_d = srpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != srpq_pkg::ST_IDLE);

endmodule

### sv/srpq_dpath.sv
// Key store, ring pointers and result registers of the sorted ring priority queue.
`timescale 1ns / 1ps
module srpq_dpath #(
  parameter int CAPACITY = srpq_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srpq_pkg::KEY_W-1:0]  key_in_i,
  input  srpq_pkg::cmd_t              cmd_i,
  output srpq_pkg::status_t           status_o,
  output logic                        done_o,
  output logic [srpq_pkg::KEY_W-1:0]  key_out_o,
  output logic                        removed_valid_o,
  output logic                        insert_rejected_o,
  output logic [srpq_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);

  logic [srpq_pkg::KEY_W-1:0] mem_q [CAPACITY];
  logic [srpq_pkg::KEY_W-1:0] rd_q;
  logic [IDX_W-1:0]           rd_addr;

  logic [IDX_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [IDX_W-1:0]           pos_q;
  logic [srpq_pkg::KEY_W-1:0] key_q;

  logic [IDX_W:0]             tail_sum;
  logic [IDX_W-1:0]           tail;
  logic [IDX_W-1:0]           tail_prev;
  logic [IDX_W-1:0]           prev;
  logic [IDX_W-1:0]           prev_prev;

  logic                        done_q;
  logic [srpq_pkg::KEY_W-1:0]  key_out_q;
  logic                        removed_q;
  logic                        rejected_q;
  logic [srpq_pkg::OCC_W-1:0]  occ_q;

  // Ring slot arithmetic.
  assign tail_sum  = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(count_q);
  assign tail      = (tail_sum >= CAP_EXT) ? IDX_W'(tail_sum - CAP_EXT) : IDX_W'(tail_sum);
  assign tail_prev = (tail == '0) ? LAST_IDX : tail - IDX_W'(1);
  assign prev      = (pos_q == '0) ? LAST_IDX : pos_q - IDX_W'(1);
  assign prev_prev = (prev == '0) ? LAST_IDX : prev - IDX_W'(1);

  // Status to the sequencer.
  assign status_o.full         = (count_q >= CNT_W'(CAPACITY));
  assign status_o.empty        = (count_q == '0);
  assign status_o.key_less     = (key_q < rd_q);
  assign status_o.prev_is_head = (prev == head_q);

  // Select the read slot.
  always_comb begin
    rd_addr = pos_q;
    if (cmd_i.rd_head) begin
      rd_addr = head_q;
    end else if (cmd_i.rd_tail_prev) begin
      rd_addr = tail_prev;
    end else if (cmd_i.rd_walk) begin
      rd_addr = prev_prev;
    end
  end

  // Key store: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_shift) begin
      mem_q[pos_q] <= rd_q;
    end else if (cmd_i.wr_key) begin
      mem_q[pos_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
  end

  // Hold the new key and walk the hole toward the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= key_in_i;
      pos_q <= tail;
    end else if (cmd_i.wr_shift) begin
      pos_q <= prev;
    end
  end

  // Ring pointer updates.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    case (cmd_i.result)
      srpq_pkg::RES_INS: begin
        count_d = count_q + CNT_W'(1);
      end
      srpq_pkg::RES_REM: begin
        head_d  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
        count_d = count_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= (cmd_i.result != srpq_pkg::RES_NONE);
    end
  end

  // Result registers, loaded when a request finishes and held until the next result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.result != srpq_pkg::RES_NONE) begin
      key_out_q  <= (cmd_i.result == srpq_pkg::RES_REM) ? rd_q : '0;
      removed_q  <= (cmd_i.result == srpq_pkg::RES_REM);
      rejected_q <= (cmd_i.result == srpq_pkg::RES_REJ);
      occ_q      <= srpq_pkg::OCC_W'(count_d);
    end
  end

  assign done_o            = done_q;
  assign key_out_o         = key_out_q;
  assign removed_valid_o   = removed_q;
  assign insert_rejected_o = rejected_q;
  assign occupancy_o       = occ_q;

endmodule

### sv/sorted_ring_priority_queue.sv
// Top level of the sorted ring priority queue.
// Usage: drive start with op_i (0 insert key_in_i, 1 remove smallest key)
// while busy is low; the request is taken at that clock edge.
// Every request yields one result: done_o pulses for one cycle with key_out_o,
// removed_valid_o, insert_rejected_o and occupancy_o valid in that cycle.
// The receiver cannot stall; results must be captured in the done_o cycle.
// Keys are held ascending from head to tail in a ring store; equal keys leave
// in arrival order.
// From request to done_o: an insert into a full queue or a remove from an empty
// one is answered straight from idle; a remove first reads the head slot; an
// insert moves each strictly larger key up one slot, walking toward the head,
// then writes the new key, as the store has a single read and write port.
// A new request can be taken in the done_o cycle.
// Reset empties the queue (head and count cleared); store contents are left
// as they are and are only read once written.
// Occupancy is reported modulo 32.
`timescale 1ns / 1ps
`include "sorted_ring_priority_queue_defines.svh"
module sorted_ring_priority_queue #(
  parameter int CAPACITY = srpq_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [srpq_pkg::KEY_W-1:0]  key_in_i,
  output logic                        done_o,
  output logic [srpq_pkg::KEY_W-1:0]  key_out_o,
  output logic                        removed_valid_o,
  output logic                        insert_rejected_o,
  output logic [srpq_pkg::OCC_W-1:0]  occupancy_o
);

  srpq_pkg::cmd_t    cmd;
  srpq_pkg::status_t status;

  // Sequencer.
  srpq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Store and result path.
  srpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .key_in_i          (key_in_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .done_o            (done_o),
    .key_out_o         (key_out_o),
    .removed_valid_o   (removed_valid_o),
    .insert_rejected_o (insert_rejected_o),
    .occupancy_o       (occupancy_o)
  );

  // Checks.
  `SRPQ_ASSERT_NEVER(a_busy_no_done, clk_i, rst_ni, busy && done_o)
  `SRPQ_ASSERT_NEVER(a_flags_excl, clk_i, rst_ni, done_o && removed_valid_o && insert_rejected_o)
  `SRPQ_ASSERT_IMPLY(a_zero_key, clk_i, rst_ni, done_o && !removed_valid_o, key_out_o == '0)

endmodule

### bench/sorted_ring_priority_queue_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted ring priority queue: directed rows, then random requests.
module sorted_ring_priority_queue_test;

  localparam int DEPTH           = srpq_pkg::CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 600;
  localparam int STALL_LIMIT     = 2000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [srpq_pkg::KEY_W-1:0] key;
    logic                       removed;
    logic                       rejected;
    logic [srpq_pkg::OCC_W-1:0] occ;
  } pq_result_t;

  typedef struct packed {
    logic                       op;
    logic [srpq_pkg::KEY_W-1:0] key;
    logic                       typed;   // use the result below instead of the predicted one
    pq_result_t                 result;
  } stim_row_t;

  logic                       clk_i    = 1'b0;
  logic                       rst_ni   = 1'b0;
  logic                       start    = 1'b0;
  logic                       op_i     = srpq_pkg::OP_INSERT;
  logic [srpq_pkg::KEY_W-1:0] key_in_i = '0;
  logic                       busy;
  logic                       done_o;
  logic [srpq_pkg::KEY_W-1:0] key_out_o;
  logic                       removed_valid_o;
  logic                       insert_rejected_o;
  logic [srpq_pkg::OCC_W-1:0] occupancy_o;

  logic [srpq_pkg::KEY_W-1:0] sorted_keys[$];     // predicted queue contents, smallest first
  pq_result_t                 pending_results[$]; // results owed by the block, oldest first
  int                         failures     = 0;
  int                         quiet_cycles = 0;

  // Empty-queue remove, both key extremes, then a descending fill with ties that walks
  // most inserts back to the head, an insert into the full queue and one remove.
  stim_row_t directed_rows[24] = '{
    '{srpq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd0}},
    '{srpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd1}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd2}},
    '{srpq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 5'd1}},
    '{srpq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0}},
    '{srpq_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd0}},
    '{srpq_pkg::OP_INSERT, 32'hF000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd1}},
    '{srpq_pkg::OP_INSERT, 32'hC000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd2}},
    '{srpq_pkg::OP_INSERT, 32'hC000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd3}},
    '{srpq_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd4}},
    '{srpq_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd5}},
    '{srpq_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd6}},
    '{srpq_pkg::OP_INSERT, 32'h5A5A_5A5A, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd7}},
    '{srpq_pkg::OP_INSERT, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd8}},
    '{srpq_pkg::OP_INSERT, 32'h0000_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd9}},
    '{srpq_pkg::OP_INSERT, 32'h0000_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd10}},
    '{srpq_pkg::OP_INSERT, 32'h0000_1000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd11}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0100, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd12}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0010, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd13}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0002, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd14}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd15}},
    '{srpq_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd16}},
    '{srpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 5'd16}},
    '{srpq_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, '0}
  };

  sorted_ring_priority_queue #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .key_in_i         (key_in_i),
    .done_o           (done_o),
    .key_out_o        (key_out_o),
    .removed_valid_o  (removed_valid_o),
    .insert_rejected_o(insert_rejected_o),
    .occupancy_o      (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the predicted queue and return the result it owes.
  function automatic pq_result_t apply_request(logic op, logic [srpq_pkg::KEY_W-1:0] key);
    pq_result_t res;
    int         slot;
    res = '0;
    if (op == srpq_pkg::OP_INSERT) begin
      if (sorted_keys.size() >= DEPTH) begin
        res.rejected = 1'b1;
      end else begin
        // walk back past strictly larger keys; equal keys keep arrival order
        slot = sorted_keys.size();
        while (slot > 0 && key < sorted_keys[slot-1]) slot--;
        sorted_keys.insert(slot, key);
      end
    end else if (sorted_keys.size() != 0) begin
      res.key     = sorted_keys.pop_front();
      res.removed = 1'b1;
    end
    res.occ = srpq_pkg::OCC_W'(sorted_keys.size());
    return res;
  endfunction

  // Mostly random keys, with extremes and a narrow range that gives many ties.
  function automatic logic [srpq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       pick_key = '0;
      1:       pick_key = '1;
      2, 3:    pick_key = srpq_pkg::KEY_W'($urandom_range(0, 7));
      default: pick_key = $urandom();
    endcase
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_request(input logic op, input logic [srpq_pkg::KEY_W-1:0] key,
                              input logic typed, input pq_result_t typed_result);
    pq_result_t predicted;
    start    <= 1'b1;
    op_i     <= op;
    key_in_i <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_request(op, key);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Drop start now and then for a random gap, with noise on the request fields.
  task automatic maybe_idle(input int pct);
    int gap;
    if ($urandom_range(1, 100) <= pct) begin
      gap = $urandom_range(1, 6);
      start    <= 1'b0;
      op_i     <= 1'($urandom());
      key_in_i <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every owed result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Compare each result with the oldest one owed.
  always @(posedge clk_i) begin : check_results
    pq_result_t seen;
    pq_result_t want;
    if (rst_ni && done_o) begin
      seen = '{key_out_o, removed_valid_o, insert_rejected_o, occupancy_o};
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: key %h removed %b rejected %b occupancy %0d",
                   seen.key, seen.removed, seen.rejected, seen.occ);
      end else begin
        want = pending_results.pop_front();
        if (seen.key !== want.key || seen.removed !== want.removed ||
            seen.rejected !== want.rejected || seen.occ !== want.occ) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display({"mismatch: expected key %h removed %b rejected %b occupancy %0d,",
                      " got key %h removed %b rejected %b occupancy %0d"},
                     want.key, want.removed, want.rejected, want.occ,
                     seen.key, seen.removed, seen.rejected, seen.occ);
        end
      end
    end
  end

  // End the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_ring_priority_queue_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic op;
    logic fill_bias;
    int   idle_pct;
    fill_bias = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                   directed_rows[i].result);

    // Sender idles rarely, then often, then never; wait for all owed results before each phase.
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 13 : (p == 1) ? 62 : 0;
      drain_results();
      for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
        // alternate filling and draining runs so both full and empty are reached
        if (n % 30 == 0) fill_bias = ~fill_bias;
        op = ($urandom_range(1, 100) <= (fill_bias ? 80 : 25)) ? srpq_pkg::OP_INSERT
                                                                 : srpq_pkg::OP_REMOVE;
        send_request(op, pick_key(), 1'b0, '0);
        maybe_idle(idle_pct);
      end
    end

    drain_results();
    repeat (DEPTH + 4) @(posedge clk_i);
    if (failures == 0) begin
      $display("sorted_ring_priority_queue_test: PASS");
    end else begin
      $display("sorted_ring_priority_queue_test: FAIL");
    end
    $finish;
  end

endmodule
